// ----- src/tmcc_pkg.sv -----
// Shared constants, command and status codes, and interface types of the tile map checker.
`default_nettype none

package tmcc_pkg;

  // Map and tileset capacity.
  localparam int MAX_MAP_WIDTH  = 64;
  localparam int MAX_MAP_HEIGHT = 64;
  localparam int MAX_LAYERS     = 8;
  localparam int MAX_TILE_KINDS = 256;

  // Cell store geometry: address is {layer, column, row}.
  localparam int X_BITS     = $clog2(MAX_MAP_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_MAP_HEIGHT);
  localparam int L_BITS     = $clog2(MAX_LAYERS);
  localparam int CELL_AW    = L_BITS + X_BITS + Y_BITS;
  localparam int CELL_DEPTH = 1 << CELL_AW;
  localparam int CODE_BITS  = $clog2(MAX_TILE_KINDS + 1);
  localparam int KIND_BITS  = $clog2(MAX_TILE_KINDS);

  // Fixed field widths.
  localparam int POS_W   = 16;
  localparam int CNT_W   = 4;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  typedef enum logic [1:0] {
    CMD_PLACE = 2'd0,
    CMD_SOLID = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TILE  = 2'd1,
    ST_OUTSIDE   = 2'd2,
    ST_BAD_LAYER = 2'd3
  } status_t;

  // Effective configuration after zero and capacity limits.
  typedef struct packed {
    logic [7:0] tw;
    logic [7:0] th;
    logic [6:0] mw;
    logic [6:0] mh;
    logic [2:0] cl;
    logic [3:0] nl;
    logic [8:0] nt;
  } cfg_t;

  typedef struct packed {
    logic                 wr;
    logic [CELL_AW-1:0]   addr;
    logic [CODE_BITS-1:0] data;
  } cell_req_t;

  typedef struct packed {
    logic                 wr;
    logic [KIND_BITS-1:0] addr;
    logic                 data;
  } solid_req_t;

endpackage

`default_nettype wire

// ----- src/tmcc_regs.sv -----
// APB configuration registers and the effective configuration derived from them.
`default_nettype none

module tmcc_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tmcc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [tmcc_pkg::APB_DW-1:0]    pwdata,
  output logic      [tmcc_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  output tmcc_pkg::cfg_t                      cfg
);

  typedef enum logic [2:0] {
    REG_TILE_W     = 3'd0,
    REG_TILE_H     = 3'd1,
    REG_MAP_W      = 3'd2,
    REG_MAP_H      = 3'd3,
    REG_COLL_LAYER = 3'd4,
    REG_LAYER_CNT  = 3'd5,
    REG_TILE_CNT   = 3'd6
  } reg_idx_t;

  logic [7:0] tile_width_px;
  logic [7:0] tile_height_px;
  logic [6:0] map_width;
  logic [6:0] map_height;
  logic [2:0] collision_layer;
  logic [3:0] layer_count;
  logic [8:0] tile_count;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width_px   <= 8'd64;
      tile_height_px  <= 8'd64;
      map_width       <= 7'd1;
      map_height      <= 7'd1;
      collision_layer <= 3'd0;
      layer_count     <= 4'd1;
      tile_count      <= 9'd256;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TILE_W:     tile_width_px   <= pwdata[7:0];
        REG_TILE_H:     tile_height_px  <= pwdata[7:0];
        REG_MAP_W:      map_width       <= pwdata[6:0];
        REG_MAP_H:      map_height      <= pwdata[6:0];
        REG_COLL_LAYER: collision_layer <= pwdata[2:0];
        REG_LAYER_CNT:  layer_count     <= pwdata[3:0];
        REG_TILE_CNT:   tile_count      <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read-back of the raw register values.
  always_comb begin
    case (reg_idx)
      REG_TILE_W:     prdata = {24'd0, tile_width_px};
      REG_TILE_H:     prdata = {24'd0, tile_height_px};
      REG_MAP_W:      prdata = {25'd0, map_width};
      REG_MAP_H:      prdata = {25'd0, map_height};
      REG_COLL_LAYER: prdata = {29'd0, collision_layer};
      REG_LAYER_CNT:  prdata = {28'd0, layer_count};
      REG_TILE_CNT:   prdata = {23'd0, tile_count};
      default:        prdata = '0;
    endcase
  end

  // A zero tile size counts as one pixel; counts are capped at the capacity.
  always_comb begin
    cfg.tw = (tile_width_px == 8'd0) ? 8'd1 : tile_width_px;
    cfg.th = (tile_height_px == 8'd0) ? 8'd1 : tile_height_px;
    cfg.mw = (map_width > 7'(tmcc_pkg::MAX_MAP_WIDTH)) ?
             7'(tmcc_pkg::MAX_MAP_WIDTH) : map_width;
    cfg.mh = (map_height > 7'(tmcc_pkg::MAX_MAP_HEIGHT)) ?
             7'(tmcc_pkg::MAX_MAP_HEIGHT) : map_height;
    cfg.cl = collision_layer;
    cfg.nl = (layer_count > 4'(tmcc_pkg::MAX_LAYERS)) ?
             4'(tmcc_pkg::MAX_LAYERS) : layer_count;
    cfg.nt = (tile_count > 9'(tmcc_pkg::MAX_TILE_KINDS)) ?
             9'(tmcc_pkg::MAX_TILE_KINDS) : tile_count;
  end

endmodule

`default_nettype wire

// ----- src/tmcc_div.sv -----
// Shared restoring divider: 16-bit dividend by 8-bit divisor, one quotient bit per cycle.
`default_nettype none

module tmcc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [7:0]  divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic [15:0] dvd;
  logic [7:0]  rem;
  logic [7:0]  dsr;
  logic [3:0]  cnt;
  logic        running;
  logic [8:0]  rem_sh;
  logic        fits;
  logic [8:0]  rem_sub;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem, dvd[15]};
    fits    = rem_sh >= {1'b0, dsr};
    rem_sub = rem_sh - {1'b0, dsr};
  end

  // Iteration control; quotient bits shift into the dividend register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      dvd <= {dvd[14:0], fits};
      rem <= fits ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

// ----- src/tmcc_store.sv -----
// Tile cell memory and solid flag memory, with the clearing pass after reset.
`default_nettype none

module tmcc_store (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tmcc_pkg::cell_req_t              cell_req,
  input  wire tmcc_pkg::solid_req_t             solid_req,
  output logic [tmcc_pkg::CODE_BITS-1:0]        cell_rdata,
  output logic                                  solid_rdata,
  output logic                                  clearing
);

  logic [tmcc_pkg::CODE_BITS-1:0] cell_mem [tmcc_pkg::CELL_DEPTH];
  logic                           solid_mem [tmcc_pkg::MAX_TILE_KINDS];
  logic [tmcc_pkg::CELL_AW-1:0]   clr_addr;
  logic                           clr_solid;

  assign clr_solid = 32'(clr_addr) < tmcc_pkg::MAX_TILE_KINDS;

  // Clearing pass: one cell per cycle, solid flags during the first entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == tmcc_pkg::CELL_AW'(tmcc_pkg::CELL_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Cell memory with registered read.
  always_ff @(posedge clk) begin
    if (clearing) begin
      cell_mem[clr_addr] <= '0;
    end else if (cell_req.wr) begin
      cell_mem[cell_req.addr] <= cell_req.data;
    end
    cell_rdata <= cell_mem[cell_req.addr];
  end

  // Solid flag memory with registered read.
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_solid) begin
        solid_mem[clr_addr[tmcc_pkg::KIND_BITS-1:0]] <= 1'b0;
      end
    end else if (solid_req.wr) begin
      solid_mem[solid_req.addr] <= solid_req.data;
    end
    solid_rdata <= solid_mem[solid_req.addr];
  end

endmodule

`default_nettype wire

// ----- src/tile_map_collision_checker.sv -----
// Top level of the tile map collision checker: command sequencer and unit wiring.
//
// Usage: a command transaction is accepted at a clock edge with start high and
// busy low. The command, position, rectangle, layer, tile and flag fields are
// sampled then. Exactly one result (ok, collide, status) follows, shown for a
// single cycle with done high; the receiver cannot stall and must take it.
// Configuration goes through the APB port, with pready always high. The user
// must write it only while busy is low and no result is pending; the block
// itself does not enforce this. Setting a solid flag, the unused command and
// every command rejected up front answer in the cycle after acceptance. Place
// or clear runs two divisions on the shared divider, then checks the cell
// position and answers. A query inside the map runs four divisions, then walks
// the covered cells, reading each cell and, for a cell that holds a tile, its
// solid flag, stopping at the first solid tile. Commands share the divider and
// the single cell memory port; one command is in flight at a time.
// After reset the block clears the cell store and solid flags, one cell per
// cycle over all 32768 cells, and holds busy high meanwhile.
`default_nettype none

module tile_map_collision_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command,
  input  wire logic signed [15:0]            pos_x,
  input  wire logic signed [15:0]            pos_y,
  input  wire logic [14:0]                   rect_width,
  input  wire logic [14:0]                   rect_height,
  input  wire logic [2:0]                    layer,
  input  wire logic [7:0]                    tile_index,
  input  wire logic                          place,
  input  wire logic                          solid,
  output logic                               done,
  output logic                               ok,
  output logic                               collide,
  output logic [1:0]                         status,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmcc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [tmcc_pkg::APB_DW-1:0]   pwdata,
  output logic [tmcc_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PLACE,
    S_WALK_RD,
    S_WALK_CELL,
    S_WALK_SOLID
  } state_t;

  state_t                          state;
  tmcc_pkg::cfg_t                  cfg;
  tmcc_pkg::cell_req_t             cell_req;
  tmcc_pkg::solid_req_t            solid_req;
  logic [tmcc_pkg::CODE_BITS-1:0]  cell_rdata;
  logic                            solid_rdata;
  logic                            clearing;

  // Latched command.
  tmcc_pkg::cmd_t                  cmd;
  logic [15:0]                     pxa;
  logic [15:0]                     pya;
  logic [15:0]                     rgt;
  logic [15:0]                     bot;
  logic                            px_neg;
  logic                            py_neg;
  logic [2:0]                      lay;
  logic [7:0]                      tidx;
  logic                            plc;

  // Division sequencing and quotients.
  logic [1:0]                      step;
  logic [15:0]                     qx0;
  logic [15:0]                     qy0;
  logic [15:0]                     qx1;
  logic [15:0]                     qy1;
  logic                            div_done;
  logic [15:0]                     div_q;
  logic [15:0]                     div_dvd;
  logic [7:0]                      div_dsr;

  // Walk position.
  logic [tmcc_pkg::X_BITS-1:0]     ci;
  logic [tmcc_pkg::Y_BITS-1:0]     cj;

  // Accept-time decode.
  logic                            accept;
  logic                            tile_bad;
  logic                            qlayer_bad;
  logic [16:0]                     right;
  logic [16:0]                     bottom;
  logic [14:0]                     map_px_w;
  logic [14:0]                     map_px_h;
  logic                            q_outside;
  logic [15:0]                     mag_x;
  logic [15:0]                     mag_y;

  // Place-time and walk-time decode.
  logic                            in_x;
  logic                            in_y;
  logic                            layer_bad;
  logic                            code_solidable;
  logic                            walk_last_row;
  logic                            walk_last_col;
  logic [tmcc_pkg::CODE_BITS-1:0]  kind;

  tmcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV_GO),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  tmcc_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cell_req    (cell_req),
    .solid_req   (solid_req),
    .cell_rdata  (cell_rdata),
    .solid_rdata (solid_rdata),
    .clearing    (clearing)
  );

  assign busy   = (state != S_IDLE) || clearing;
  assign accept = start && !busy;

  // Checks made on the incoming command.
  always_comb begin
    tile_bad   = {1'b0, tile_index} >= cfg.nt;
    qlayer_bad = {1'b0, cfg.cl} >= cfg.nl;
    right      = {2'b00, pos_x[14:0]} + {2'b00, rect_width};
    bottom     = {2'b00, pos_y[14:0]} + {2'b00, rect_height};
    map_px_w   = 15'(cfg.mw) * 15'(cfg.tw);
    map_px_h   = 15'(cfg.mh) * 15'(cfg.th);
    q_outside  = pos_x[15] || (right >= {2'b00, map_px_w}) ||
                 pos_y[15] || (bottom >= {2'b00, map_px_h});
    mag_x      = pos_x[15] ? (~pos_x + 16'd1) : pos_x;
    mag_y      = pos_y[15] ? (~pos_y + 16'd1) : pos_y;
  end

  // Divider operand selection by step.
  always_comb begin
    case (step)
      2'd0:    div_dvd = pxa;
      2'd1:    div_dvd = pya;
      2'd2:    div_dvd = rgt;
      default: div_dvd = bot;
    endcase
    div_dsr = step[0] ? cfg.th : cfg.tw;
  end

  // Truncation toward zero: a negative position maps to cell 0 only when its
  // magnitude is below one tile.
  always_comb begin
    in_x      = (!px_neg || (qx0 == 16'd0)) && (qx0 < {9'd0, cfg.mw});
    in_y      = (!py_neg || (qy0 == 16'd0)) && (qy0 < {9'd0, cfg.mh});
    layer_bad = {1'b0, lay} >= cfg.nl;
    kind      = cell_rdata - tmcc_pkg::CODE_BITS'(1);
    code_solidable = (cell_rdata != '0) &&
                     (32'(cell_rdata) <= tmcc_pkg::MAX_TILE_KINDS);
    walk_last_row = (cj == qy1[tmcc_pkg::Y_BITS-1:0]);
    walk_last_col = (ci == qx1[tmcc_pkg::X_BITS-1:0]);
  end

  // Memory requests.
  always_comb begin
    cell_req.wr   = (state == S_PLACE) && in_x && in_y && !layer_bad;
    cell_req.data = plc ? (tmcc_pkg::CODE_BITS'(tidx) + tmcc_pkg::CODE_BITS'(1)) : '0;
    if (state == S_PLACE) begin
      cell_req.addr = {lay[tmcc_pkg::L_BITS-1:0], qx0[tmcc_pkg::X_BITS-1:0],
                       qy0[tmcc_pkg::Y_BITS-1:0]};
    end else begin
      cell_req.addr = {cfg.cl[tmcc_pkg::L_BITS-1:0], ci, cj};
    end
    solid_req.wr   = accept && (command == tmcc_pkg::CMD_SOLID) && !tile_bad;
    solid_req.data = solid;
    if (state == S_WALK_CELL) begin
      solid_req.addr = kind[tmcc_pkg::KIND_BITS-1:0];
    end else begin
      solid_req.addr = tile_index[tmcc_pkg::KIND_BITS-1:0];
    end
  end

  // Sequencer with registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      ok      <= 1'b0;
      collide <= 1'b0;
      status  <= tmcc_pkg::ST_OK;
      step    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd    <= tmcc_pkg::cmd_t'(command);
            pxa    <= mag_x;
            pya    <= mag_y;
            rgt    <= right[15:0];
            bot    <= bottom[15:0];
            px_neg <= pos_x[15];
            py_neg <= pos_y[15];
            lay    <= layer;
            tidx   <= tile_index;
            plc    <= place;
            step   <= '0;
            ok      <= 1'b0;
            collide <= 1'b0;
            status  <= tmcc_pkg::ST_OK;
            case (tmcc_pkg::cmd_t'(command))
              tmcc_pkg::CMD_PLACE: begin
                if (tile_bad) begin
                  done   <= 1'b1;
                  status <= tmcc_pkg::ST_BAD_TILE;
                end else begin
                  state <= S_DIV_GO;
                end
              end
              tmcc_pkg::CMD_SOLID: begin
                done <= 1'b1;
                if (tile_bad) begin
                  status <= tmcc_pkg::ST_BAD_TILE;
                end else begin
                  ok <= 1'b1;
                end
              end
              tmcc_pkg::CMD_QUERY: begin
                if (q_outside) begin
                  done    <= 1'b1;
                  ok      <= 1'b1;
                  collide <= 1'b1;
                  status  <= tmcc_pkg::ST_OUTSIDE;
                end else if (qlayer_bad) begin
                  done   <= 1'b1;
                  status <= tmcc_pkg::ST_BAD_LAYER;
                end else begin
                  state <= S_DIV_GO;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            case (step)
              2'd0:    qx0 <= div_q;
              2'd1:    qy0 <= div_q;
              2'd2:    qx1 <= div_q;
              default: qy1 <= div_q;
            endcase
            if ((cmd == tmcc_pkg::CMD_PLACE) && (step == 2'd1)) begin
              state <= S_PLACE;
            end else if (step == 2'd3) begin
              ci    <= qx0[tmcc_pkg::X_BITS-1:0];
              cj    <= qy0[tmcc_pkg::Y_BITS-1:0];
              state <= S_WALK_RD;
            end else begin
              step  <= step + 2'd1;
              state <= S_DIV_GO;
            end
          end
        end

        S_PLACE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (!(in_x && in_y)) begin
            status <= tmcc_pkg::ST_OUTSIDE;
          end else if (layer_bad) begin
            status <= tmcc_pkg::ST_BAD_LAYER;
          end else begin
            ok <= 1'b1;
          end
        end

        S_WALK_RD: begin
          state <= S_WALK_CELL;
        end

        S_WALK_CELL, S_WALK_SOLID: begin
          if ((state == S_WALK_CELL) && code_solidable) begin
            state <= S_WALK_SOLID;
          end else if ((state == S_WALK_SOLID) && solid_rdata) begin
            done    <= 1'b1;
            ok      <= 1'b1;
            collide <= 1'b1;
            state   <= S_IDLE;
          end else if (walk_last_row && walk_last_col) begin
            done  <= 1'b1;
            ok    <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (walk_last_row) begin
              cj <= qy0[tmcc_pkg::Y_BITS-1:0];
              ci <= ci + 1'b1;
            end else begin
              cj <= cj + 1'b1;
            end
            state <= S_WALK_RD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result appears only after an accepted command or from a busy sequencer.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept || (state != S_IDLE)))
    else $error("result strobe without a command in progress");

  // No command is taken while the clearing pass runs.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy)
    else $error("block idle during clearing pass");

  // Cells are written only by a successful place or clear.
  a_cell_write_source: assert property (@(posedge clk) disable iff (rst)
    cell_req.wr |=> (done && ok && (cmd == tmcc_pkg::CMD_PLACE)))
    else $error("cell write without a successful place result");

  // A reported collision always comes from a query answered with ok high.
  a_collide_ok: assert property (@(posedge clk) disable iff (rst)
    (done && collide) |-> (ok && (cmd == tmcc_pkg::CMD_QUERY)))
    else $error("collision reported outside a query");

  // The walk stays inside the covered cell range.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_RD) |->
      ((ci <= qx1[tmcc_pkg::X_BITS-1:0]) && (cj <= qy1[tmcc_pkg::Y_BITS-1:0])))
    else $error("cell walk left the covered range");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the tile map collision checker: directed and random commands.
`timescale 1ns / 100ps

module testbench;
  import tmcc_pkg::*;

  // The cycle limit leaves room for the slowest correct run: the clearing pass, about 900
  // commands, and a handful of whole-map sweeps.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int REG_TOTAL   = 7;
  localparam int SETTLE      = 200;

  typedef enum int {
    RG_TILE_W     = 0,
    RG_TILE_H     = 1,
    RG_COLS       = 2,
    RG_ROWS       = 3,
    RG_COLL_LAYER = 4,
    RG_LAYERS     = 5,
    RG_KINDS      = 6
  } reg_index_t;

  typedef struct {
    logic [7:0] tile_w;
    logic [7:0] tile_h;
    logic [6:0] cols;
    logic [6:0] rows;
    logic [2:0] coll_layer;
    logic [3:0] layers;
    logic [8:0] kinds;
  } map_settings_t;

  typedef struct {
    cmd_t               command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic [2:0]         layer;
    logic [7:0]         tile_index;
    logic               place;
    logic               solid;
  } tile_cmd_t;

  typedef struct {
    logic    ok;
    logic    collide;
    status_t status;
    cmd_t    command;
    int      seq;
  } tile_answer_t;

  // Block ports.
  logic                clk;
  logic                rst         = 1'b1;
  logic                start       = 1'b0;
  logic                busy;
  logic [1:0]          command     = CMD_NONE;
  logic signed [15:0]  pos_x       = '0;
  logic signed [15:0]  pos_y       = '0;
  logic [14:0]         rect_width  = '0;
  logic [14:0]         rect_height = '0;
  logic [2:0]          layer       = '0;
  logic [7:0]          tile_index  = '0;
  logic                place       = 1'b0;
  logic                solid       = 1'b0;
  logic                done;
  logic                ok;
  logic                collide;
  logic [1:0]          status;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  tile_map_collision_checker DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .pos_x(pos_x), .pos_y(pos_y),
    .rect_width(rect_width), .rect_height(rect_height),
    .layer(layer), .tile_index(tile_index), .place(place), .solid(solid),
    .done(done), .ok(ok), .collide(collide), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted map contents: cell code 0 is empty, otherwise tile number plus one.
  logic [8:0]    tile_code [CELL_DEPTH];
  logic          solid_kind [MAX_TILE_KINDS];
  map_settings_t settings;
  int            eff_tw, eff_th, eff_cols, eff_rows, eff_layers, eff_kinds;

  tile_answer_t  pending_answers [$];
  int            issued;
  int            failures;
  int            cycle_count;
  bit            back_to_back;

  task automatic report_mismatch(input string what);
    failures++;
    if (failures <= 40) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  function automatic int below(input int n);
    return (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
  endfunction

  function automatic int cell_slot(input int lay, input int x, input int y);
    return (lay * MAX_MAP_WIDTH + x) * MAX_MAP_HEIGHT + y;
  endfunction

  // Derive the working sizes: zero tile size counts as one, counts are capped.
  function automatic void adopt_settings(input map_settings_t s);
    settings   = s;
    eff_tw     = (s.tile_w == 0) ? 1 : int'(s.tile_w);
    eff_th     = (s.tile_h == 0) ? 1 : int'(s.tile_h);
    eff_cols   = (s.cols > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : int'(s.cols);
    eff_rows   = (s.rows > MAX_MAP_HEIGHT) ? MAX_MAP_HEIGHT : int'(s.rows);
    eff_layers = (s.layers > MAX_LAYERS) ? MAX_LAYERS : int'(s.layers);
    eff_kinds  = (s.kinds > MAX_TILE_KINDS) ? MAX_TILE_KINDS : int'(s.kinds);
  endfunction

  function automatic logic [31:0] register_value(input map_settings_t s, input reg_index_t idx);
    case (idx)
      RG_TILE_W:     return 32'(s.tile_w);
      RG_TILE_H:     return 32'(s.tile_h);
      RG_COLS:       return 32'(s.cols);
      RG_ROWS:       return 32'(s.rows);
      RG_COLL_LAYER: return 32'(s.coll_layer);
      RG_LAYERS:     return 32'(s.layers);
      default:       return 32'(s.kinds);
    endcase
  endfunction

  // Work out the answer to one command and apply its effect to the predicted map.
  function automatic tile_answer_t predict_answer(input tile_cmd_t c);
    tile_answer_t a;
    int px, py, right, bottom, cx, cy, x0, x1, y0, y1;
    logic [8:0] code;
    a.ok = 1'b0;
    a.collide = 1'b0;
    a.status = ST_OK;
    a.command = c.command;
    a.seq = issued;
    px = int'(c.pos_x);
    py = int'(c.pos_y);
    case (c.command)
      CMD_PLACE: begin
        cx = px / eff_tw;
        cy = py / eff_th;
        if (int'(c.tile_index) >= eff_kinds) begin
          a.status = ST_BAD_TILE;
        end else if (cx < 0 || cx >= eff_cols || cy < 0 || cy >= eff_rows) begin
          a.status = ST_OUTSIDE;
        end else if (int'(c.layer) >= eff_layers) begin
          a.status = ST_BAD_LAYER;
        end else begin
          tile_code[cell_slot(c.layer, cx, cy)] = c.place ? 9'(c.tile_index) + 9'd1 : 9'd0;
          a.ok = 1'b1;
        end
      end
      CMD_SOLID: begin
        if (int'(c.tile_index) >= eff_kinds) begin
          a.status = ST_BAD_TILE;
        end else begin
          solid_kind[c.tile_index] = c.solid;
          a.ok = 1'b1;
        end
      end
      CMD_QUERY: begin
        right  = px + int'(c.rect_width);
        bottom = py + int'(c.rect_height);
        if (px < 0 || right >= eff_cols * eff_tw || py < 0 || bottom >= eff_rows * eff_th) begin
          a.ok = 1'b1;
          a.collide = 1'b1;
          a.status = ST_OUTSIDE;
        end else if (int'(settings.coll_layer) >= eff_layers) begin
          a.status = ST_BAD_LAYER;
        end else begin
          x0 = px / eff_tw;
          x1 = right / eff_tw;
          y0 = py / eff_th;
          y1 = bottom / eff_th;
          for (int i = x0; i <= x1 && !a.collide; i++) begin
            for (int j = y0; j <= y1 && !a.collide; j++) begin
              code = tile_code[cell_slot(settings.coll_layer, i, j)];
              if (code != 0 && solid_kind[code - 9'd1]) a.collide = 1'b1;
            end
          end
          a.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic tile_cmd_t make_cmd(input cmd_t op, input int x, input int y, input int w,
                                         input int h, input int lay, input int tile,
                                         input bit put, input bit hard);
    tile_cmd_t c;
    c.command     = op;
    c.pos_x       = 16'(x);
    c.pos_y       = 16'(y);
    c.rect_width  = 15'(w);
    c.rect_height = 15'(h);
    c.layer       = 3'(lay);
    c.tile_index  = 8'(tile);
    c.place       = put;
    c.solid       = hard;
    return c;
  endfunction

  // Cells near the origin get most of the traffic so that queries meet placed tiles.
  function automatic int hot_coord(input int n);
    return ($urandom_range(0, 1) == 0) ? below((n < 6) ? n : 6) : below(n);
  endfunction

  function automatic int pick_tile();
    case ($urandom_range(0, 9))
      0:       return int'($urandom_range(0, 255));
      1:       return (eff_kinds < MAX_TILE_KINDS) ? eff_kinds : 255;
      2, 3, 4: return below((eff_kinds < 16) ? eff_kinds : 16);
      default: return below(eff_kinds);
    endcase
  endfunction

  // Mostly well-formed commands aimed inside the map, with some noise and some misses.
  function automatic tile_cmd_t random_command();
    tile_cmd_t c;
    int pick, px, py, rw, rh, map_w, map_h;
    c = make_cmd(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    pick  = $urandom_range(0, 99);
    map_w = eff_cols * eff_tw;
    map_h = eff_rows * eff_th;
    px = hot_coord(eff_cols) * eff_tw + below(eff_tw);
    py = hot_coord(eff_rows) * eff_th + below(eff_th);
    if (pick < 10) return c;
    if (pick < 40) begin
      c.command = CMD_PLACE;
      // Small negative positions truncate into the first row or column.
      if ($urandom_range(0, 9) == 0) px = -below(eff_tw);
      if ($urandom_range(0, 9) == 0) py = -below(eff_th);
      c.pos_x = 16'(px);
      c.pos_y = 16'(py);
      if ($urandom_range(0, 7) != 0 && eff_layers > 0) begin
        c.layer = ($urandom_range(0, 1) == 0) ? settings.coll_layer : 3'(below(eff_layers));
      end
      c.tile_index = 8'(pick_tile());
      c.place = ($urandom_range(0, 4) != 0);
    end else if (pick < 55) begin
      c.command = CMD_SOLID;
      c.tile_index = 8'(pick_tile());
      c.solid = ($urandom_range(0, 9) < 6);
    end else if (pick < 97) begin
      c.command = CMD_QUERY;
      if ($urandom_range(0, 49) == 0) begin
        // Whole-map sweep.
        px = 0;
        py = 0;
        rw = map_w - 1;
        rh = map_h - 1;
      end else begin
        rw = below(((3 * eff_tw + 1) < (map_w - px)) ? 3 * eff_tw + 1 : map_w - px);
        rh = below(((3 * eff_th + 1) < (map_h - py)) ? 3 * eff_th + 1 : map_h - py);
        // Rectangles that end exactly on the map edge are outside.
        if ($urandom_range(0, 9) == 0 && map_w > px) rw = map_w - px;
        if ($urandom_range(0, 9) == 0 && map_h > py) rh = map_h - py;
      end
      c.pos_x = 16'(px);
      c.pos_y = 16'(py);
      c.rect_width = 15'(rw);
      c.rect_height = 15'(rh);
    end else begin
      c.command = CMD_NONE;
    end
    return c;
  endfunction

  function automatic map_settings_t draw_settings();
    map_settings_t s;
    case ($urandom_range(0, 5))
      0:       s.tile_w = 8'd0;
      1:       s.tile_w = 8'd255;
      default: s.tile_w = 8'($urandom_range(1, 48));
    endcase
    case ($urandom_range(0, 5))
      0:       s.tile_h = 8'd0;
      1:       s.tile_h = 8'd255;
      default: s.tile_h = 8'($urandom_range(1, 48));
    endcase
    s.cols = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(1, 12));
    s.rows = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(1, 12));
    s.coll_layer = 3'($urandom_range(0, 7));
    s.layers = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(s.coll_layer + 1, 8));
    s.kinds = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(1, 256));
    return s;
  endfunction

  // Present one command, hold it until the block takes it, then predict its answer.
  task automatic issue_command(input tile_cmd_t c);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= c.command;
    pos_x       <= c.pos_x;
    pos_y       <= c.pos_y;
    rect_width  <= c.rect_width;
    rect_height <= c.rect_height;
    layer       <= c.layer;
    tile_index  <= c.tile_index;
    place       <= c.place;
    solid       <= c.solid;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    issued++;
    pending_answers.push_back(predict_answer(c));
  endtask

  // Drop start and wait until the block is free and every answer has come back.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (busy !== 1'b0 || pending_answers.size() != 0) @(posedge clk);
  endtask

  // One APB transfer; psel stays high so that transfers can follow back to back.
  task automatic apb_access(input reg_index_t idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
  endtask

  // Write every register, read each one back, then switch the predictor over.
  task automatic apply_settings(input map_settings_t s);
    logic [31:0] readback;
    wait_idle();
    for (int i = 0; i < REG_TOTAL; i++) begin
      apb_access(reg_index_t'(i), 1'b1, register_value(s, reg_index_t'(i)), readback);
    end
    for (int i = 0; i < REG_TOTAL; i++) begin
      apb_access(reg_index_t'(i), 1'b0, '0, readback);
      if (readback !== register_value(s, reg_index_t'(i))) begin
        report_mismatch($sformatf("register %s reads %0h, written %0h", reg_index_t'(i),
                                  readback, register_value(s, reg_index_t'(i))));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    adopt_settings(s);
  endtask

  // Reset values: one 64x64 pixel cell, one layer, full tileset.
  task automatic test_reset_state();
    issue_command(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_PLACE, -63, -63, 0, 0, 0, 255, 1, 0));
    issue_command(make_cmd(CMD_QUERY, 0, 0, 63, 63, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_SOLID, 0, 0, 0, 0, 0, 255, 0, 1));
    issue_command(make_cmd(CMD_QUERY, 0, 0, 63, 63, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_QUERY, 0, 0, 64, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_QUERY, -1, 0, 0, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_PLACE, -64, 0, 0, 0, 0, 3, 1, 0));
    issue_command(make_cmd(CMD_PLACE, 0, 0, 0, 0, 1, 3, 1, 0));
    issue_command(make_cmd(CMD_PLACE, 32767, -32768, 32767, 32767, 7, 0, 1, 1));
    issue_command(make_cmd(CMD_QUERY, 32767, 32767, 32767, 32767, 7, 255, 1, 1));
    issue_command(make_cmd(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, 1, 1));
  endtask

  // Zero tile width, oversized counts capped, far corner of a full-size map.
  task automatic test_wide_extremes();
    apply_settings('{8'd0, 8'd255, 7'd127, 7'd64, 3'd7, 4'd15, 9'd511});
    issue_command(make_cmd(CMD_PLACE, 63, 63 * 255, 0, 0, 7, 0, 1, 0));
    issue_command(make_cmd(CMD_SOLID, 0, 0, 0, 0, 0, 0, 0, 1));
    issue_command(make_cmd(CMD_QUERY, 63, 63 * 255, 0, 254, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_QUERY, 0, 0, 63, 64 * 255 - 1, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_PLACE, 64, 0, 0, 0, 7, 0, 1, 0));
    issue_command(make_cmd(CMD_PLACE, 63, 63 * 255, 0, 0, 7, 0, 0, 0));
    issue_command(make_cmd(CMD_QUERY, 63, 63 * 255, 0, 254, 0, 0, 0, 0));
  endtask

  // Zero map size, zero layers and an empty tileset reject everything.
  task automatic test_empty_limits();
    apply_settings('{8'd1, 8'd1, 7'd0, 7'd0, 3'd0, 4'd0, 9'd0});
    issue_command(make_cmd(CMD_PLACE, 0, 0, 0, 0, 0, 0, 1, 0));
    issue_command(make_cmd(CMD_SOLID, 0, 0, 0, 0, 0, 255, 0, 1));
    issue_command(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Index equal to the tile count, bad layers, and cells kept across map resizes.
  task automatic test_rejections_and_retention();
    apply_settings('{8'd1, 8'd1, 7'd2, 7'd2, 3'd1, 4'd1, 9'd5});
    issue_command(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_PLACE, 0, 0, 0, 0, 0, 5, 0, 0));
    issue_command(make_cmd(CMD_PLACE, 1, 1, 0, 0, 0, 4, 1, 0));
    issue_command(make_cmd(CMD_PLACE, 1, 1, 0, 0, 1, 4, 1, 0));
    issue_command(make_cmd(CMD_SOLID, 0, 0, 0, 0, 0, 5, 0, 1));
    issue_command(make_cmd(CMD_SOLID, 0, 0, 0, 0, 0, 4, 0, 1));
    apply_settings('{8'd1, 8'd1, 7'd1, 7'd1, 3'd0, 4'd1, 9'd5});
    issue_command(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    issue_command(make_cmd(CMD_QUERY, 0, 0, 1, 0, 0, 0, 0, 0));
    apply_settings('{8'd1, 8'd1, 7'd2, 7'd2, 3'd0, 4'd1, 9'd5});
    issue_command(make_cmd(CMD_QUERY, 1, 1, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(input map_settings_t s, input int count);
    apply_settings(s);
    for (int n = 0; n < count; n++) begin
      // Alternate stretches of back-to-back commands with randomly spaced ones.
      if ($urandom_range(0, 24) == 0) back_to_back = !back_to_back;
      issue_command(random_command());
    end
  endtask

  // Compare each answer with the oldest prediction.
  always @(posedge clk) begin
    tile_answer_t want;
    if (!rst && done === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("answer ok=%b collide=%b status=%0d with no command waiting",
                                  ok, collide, status));
      end else begin
        want = pending_answers.pop_front();
        if (ok !== want.ok || collide !== want.collide || status !== want.status) begin
          report_mismatch($sformatf("transaction %0d %s: ok=%b collide=%b status=%0d, %s%b %b %s",
                                    want.seq, want.command.name(), ok, collide, status,
                                    "predicted ", want.ok, want.collide, want.status.name()));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (tile_code[i]) tile_code[i] = '0;
    foreach (solid_kind[i]) solid_kind[i] = 1'b0;
    adopt_settings('{8'd64, 8'd64, 7'd1, 7'd1, 3'd0, 4'd1, 9'd256});
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_wide_extremes();
    test_empty_limits();
    test_rejections_and_retention();
    test_random_traffic('{8'd255, 8'd255, 7'd64, 7'd64, 3'd7, 4'd8, 9'd256}, 150);
    test_random_traffic('{8'd1, 8'd1, 7'd127, 7'd127, 3'd0, 4'd15, 9'd256}, 150);
    for (int p = 0; p < 4; p++) begin
      test_random_traffic(draw_settings(), 150);
    end

    // Let any stray answer show up before judging the run.
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && pending_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
